// ----- rtl/core/lru_set_assoc_cache_sim_assert.svh -----
// Assertion macros used by the cache RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef LRU_SET_ASSOC_CACHE_SIM_ASSERT_SVH
`define LRU_SET_ASSOC_CACHE_SIM_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clock, rst_n, ante, cons)
`define ASSERT_NEXT(label, clock, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/lsac_pkg.sv -----
`default_nettype none

package lsac_pkg;

	// Sizing of the cache model.
	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int ADDR_WIDTH   = 64;
	localparam int COUNT_WIDTH  = 32;

	// Fixed widths of the ports.
	localparam int IN_ADDR_W = 64;
	localparam int TOTAL_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 6;

	// Derived widths.
	localparam int NUM_SETS = 2 ** MAX_SET_BITS;
	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int OLD_W    = $clog2(MAX_WAYS + 1) + 1;
	localparam int WCNT_W   = $clog2(MAX_WAYS + 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [2:0] RST_SET_BITS    = 3'd4;
	localparam logic [3:0] RST_WAYS_IN_USE = 4'd1;
	localparam logic [5:0] RST_BLOCK_BITS  = 6'd4;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	// One cache line as kept in a set row.
	typedef struct packed {
		logic                  valid;
		logic [RANK_W-1:0]     rank;
		logic [ADDR_WIDTH-1:0] tag;
	} way_t;

	typedef way_t [MAX_WAYS-1:0] row_t;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Saturating increment of a running counter.
	function automatic count_t sat_inc(input count_t c);
		return (c == '1) ? c : count_t'(c + count_t'(1));
	endfunction

	// Low bits of a counter as reported on the ports.
	function automatic logic [TOTAL_W-1:0] fit_total(input count_t c);
		logic [63:0] w;
		w = 64'(c);
		return w[TOTAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lsac_ram.sv -----
`default_nettype none

module lsac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/lsac_update.sv -----
`default_nettype none

module lsac_update (
	input  lsac_pkg::row_t                      rd_row,
	input  logic                                row_init,
	input  logic [lsac_pkg::ADDR_WIDTH-1:0]     tag,
	input  logic [lsac_pkg::WCNT_W-1:0]         ways,
	output lsac_pkg::row_t                      wr_row,
	output lsac_pkg::outcome_t                  outcome
);

	import lsac_pkg::*;

	// Lookup, replacement choice and rank update of one set row.
	always_comb begin
		row_t              cur;
		logic [MAX_WAYS-1:0] in_use;
		logic [MAX_WAYS-1:0] hit_v;
		logic [MAX_WAYS-1:0] free_v;
		logic [WAY_W-1:0]  hit_w;
		logic [WAY_W-1:0]  free_w;
		logic [WAY_W-1:0]  vic_w;
		logic [WAY_W-1:0]  sel_w;
		logic [OLD_W-1:0]  old_rank;

		// A set never written since reset reads as all lines invalid.
		cur = rd_row;
		for (int v = 0; v < MAX_WAYS; v++) begin
			if (!row_init) begin
				cur[v].valid = 1'b0;
				cur[v].rank  = '0;
			end
		end

		for (int v = 0; v < MAX_WAYS; v++) begin
			in_use[v] = (WCNT_W'(v) < ways);
			hit_v[v]  = in_use[v] && cur[v].valid && (cur[v].tag == tag);
			free_v[v] = in_use[v] && !cur[v].valid;
		end

		// Lowest matching way and lowest free way.
		hit_w  = '0;
		free_w = '0;
		for (int v = MAX_WAYS - 1; v >= 0; v--) begin
			if (hit_v[v]) begin
				hit_w = WAY_W'(v);
			end
			if (free_v[v]) begin
				free_w = WAY_W'(v);
			end
		end

		// Oldest in-use way; the lowest way wins a tie.
		vic_w = '0;
		for (int v = 1; v < MAX_WAYS; v++) begin
			if (in_use[v] && (cur[v].rank > cur[vic_w].rank)) begin
				vic_w = WAY_W'(v);
			end
		end

		priority if (|hit_v) begin
			outcome  = OUT_HIT;
			sel_w    = hit_w;
			old_rank = OLD_W'(cur[hit_w].rank);
		end else if (|free_v) begin
			outcome  = OUT_FILL;
			sel_w    = free_w;
			old_rank = OLD_W'(MAX_WAYS);
		end else begin
			outcome  = OUT_EVICT;
			sel_w    = vic_w;
			old_rank = OLD_W'(cur[vic_w].rank);
		end

		// Age every younger valid line and make the chosen one the newest.
		wr_row = cur;
		for (int v = 0; v < MAX_WAYS; v++) begin
			if (WAY_W'(v) == sel_w) begin
				wr_row[v].rank = '0;
				if (outcome != OUT_HIT) begin
					wr_row[v].tag   = tag;
					wr_row[v].valid = 1'b1;
				end
			end else if (in_use[v] && cur[v].valid &&
				     (OLD_W'(cur[v].rank) < old_rank) &&
				     (cur[v].rank < RANK_W'(MAX_WAYS - 1))) begin
				wr_row[v].rank = RANK_W'(cur[v].rank + RANK_W'(1));
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lru_set_assoc_cache_sim.sv -----
// Set-associative cache lookup with least-recently-used replacement.
// The request is looked up in ST_LOOKUP and its result is registered when it
// leaves that state; a new request is taken only in ST_IDLE, once the
// read-modify-write of the set row through the single set memory is done.
// Reset: configuration returns to its defaults, counters clear, and every set
// is marked unwritten at once, so no clearing pass is needed.
`default_nettype none
`include "lru_set_assoc_cache_sim_assert.svh"

module lru_set_assoc_cache_sim (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [lsac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsac_pkg::CFG_DAT_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lsac_pkg::IN_ADDR_W-1:0]    address,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        outcome,
	output logic [lsac_pkg::TOTAL_W-1:0]      hit_total,
	output logic [lsac_pkg::TOTAL_W-1:0]      miss_total,
	output logic [lsac_pkg::TOTAL_W-1:0]      eviction_total
);

	import lsac_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t                state_q;
	logic [2:0]            set_bits_q;
	logic [3:0]            ways_in_use_q;
	logic [5:0]            block_bits_q;
	logic [NUM_SETS-1:0]   set_init_q;
	count_t                hit_q;
	count_t                miss_q;
	count_t                evict_q;
	logic                  out_valid_q;
	outcome_t              outcome_q;
	logic [TOTAL_W-1:0]    hit_total_q;
	logic [TOTAL_W-1:0]    miss_total_q;
	logic [TOTAL_W-1:0]    evict_total_q;
	logic [ADDR_WIDTH-1:0] tag_s1;
	logic [SET_W-1:0]      set_s1;

	logic                  accept;
	logic                  done;
	logic [3:0]            s_eff;
	logic [WCNT_W-1:0]     ways_eff;
	logic [ADDR_WIDTH-1:0] addr_m;
	logic [ADDR_WIDTH-1:0] addr_blk;
	logic [SET_W-1:0]      set_mask;
	logic [SET_W-1:0]      set_idx;
	logic [ADDR_WIDTH-1:0] tag_idx;
	row_t                  rd_row;
	row_t                  wr_row;
	outcome_t              upd_outcome;
	count_t                hit_next;
	count_t                miss_next;
	count_t                evict_next;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= RST_SET_BITS;
			ways_in_use_q <= RST_WAYS_IN_USE;
			block_bits_q  <= RST_BLOCK_BITS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SET_BITS:    set_bits_q    <= cfg_data[2:0];
				CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data[3:0];
				CFG_BLOCK_BITS:  block_bits_q  <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// Effective split and associativity.
	assign s_eff = (32'(set_bits_q) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : 4'(set_bits_q);

	always_comb begin
		if (ways_in_use_q == 4'd0) begin
			ways_eff = WCNT_W'(1);
		end else if (32'(ways_in_use_q) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_in_use_q);
		end
	end

	// Address split into set index and tag.
	assign addr_m   = address[ADDR_WIDTH-1:0];
	assign addr_blk = addr_m >> block_bits_q;
	assign set_mask = SET_W'((32'd1 << s_eff) - 32'd1);
	assign set_idx  = addr_blk[SET_W-1:0] & set_mask;
	assign tag_idx  = addr_m >> (7'(s_eff) + 7'(block_bits_q));

	// Handshakes.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign done     = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall);

	// Request fields held through the lookup.
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1 <= tag_idx;
			set_s1 <= set_idx;
		end
	end

	// Set memory: one row holds all ways of a set.
	lsac_ram #(
		.WIDTH($bits(row_t)),
		.DEPTH(NUM_SETS)
	) u_set_ram (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(set_idx),
		.rd_data(rd_row),
		.wr_en  (done),
		.wr_addr(set_s1),
		.wr_data(wr_row)
	);

	lsac_update u_update (
		.rd_row  (rd_row),
		.row_init(set_init_q[set_s1]),
		.tag     (tag_s1),
		.ways    (ways_eff),
		.wr_row  (wr_row),
		.outcome (upd_outcome)
	);

	// Counter updates for the access being retired.
	assign hit_next   = (upd_outcome == OUT_HIT) ? sat_inc(hit_q) : hit_q;
	assign miss_next  = (upd_outcome != OUT_HIT) ? sat_inc(miss_q) : miss_q;
	assign evict_next = (upd_outcome == OUT_EVICT) ? sat_inc(evict_q) : evict_q;

	// Sequencer, counters and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			set_init_q    <= '0;
			hit_q         <= '0;
			miss_q        <= '0;
			evict_q       <= '0;
			out_valid_q   <= 1'b0;
			outcome_q     <= OUT_HIT;
			hit_total_q   <= '0;
			miss_total_q  <= '0;
			evict_total_q <= '0;
		end else begin
			// A new result replaces one that is leaving; otherwise a taken result clears.
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (done) begin
						state_q             <= ST_IDLE;
						set_init_q[set_s1]  <= 1'b1;
						hit_q               <= hit_next;
						miss_q              <= miss_next;
						evict_q             <= evict_next;
						outcome_q           <= upd_outcome;
						hit_total_q         <= fit_total(hit_next);
						miss_total_q        <= fit_total(miss_next);
						evict_total_q       <= fit_total(evict_next);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign outcome        = outcome_q;
	assign hit_total      = hit_total_q;
	assign miss_total     = miss_total_q;
	assign eviction_total = evict_total_q;

	// An accepted request is looked up in the following cycle.
	`ASSERT_NEXT(a_accept_lookup, clk, arst_n, accept, state_q == ST_LOOKUP)
	// Evictions are a subset of misses, so their count never passes the misses.
	`ASSERT_IMPLIES(a_evict_le_miss, clk, arst_n, 1'b1, miss_q >= evict_q)
	// The first access to a set after reset always fills a free way.
	`ASSERT_IMPLIES(a_first_fill, clk, arst_n, done && !set_init_q[set_s1],
		upd_outcome == OUT_FILL)

endmodule

`default_nettype wire

// ----- sim/cache_outcome_check.sv -----
`timescale 1ns / 100ps

// Watches the request and result channels of the cache model, keeps its own copy of
// the cache state, and compares each result with the outcome predicted for it.
module cache_outcome_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [lsac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsac_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [lsac_pkg::IN_ADDR_W-1:0] address,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [1:0]                     outcome,
	input  logic [lsac_pkg::TOTAL_W-1:0]   hit_total,
	input  logic [lsac_pkg::TOTAL_W-1:0]   miss_total,
	input  logic [lsac_pkg::TOTAL_W-1:0]   eviction_total,
	output int                             mismatches,
	output int                             outstanding
);

	import lsac_pkg::*;

	localparam int LINES = NUM_SETS * MAX_WAYS;

	typedef struct packed {
		outcome_t           outcome;
		logic [TOTAL_W-1:0] hits;
		logic [TOTAL_W-1:0] misses;
		logic [TOTAL_W-1:0] evictions;
	} access_result_t;

	// Shadow of the configuration registers.
	logic [2:0] set_bits;
	logic [3:0] ways_in_use;
	logic [5:0] block_bits;

	// Shadow of the cache lines and the running totals.
	logic                  line_valid [LINES];
	logic [63:0]           line_tag   [LINES];
	logic [RANK_W-1:0]     line_rank  [LINES];
	logic [TOTAL_W-1:0]    hit_count;
	logic [TOTAL_W-1:0]    miss_count;
	logic [TOTAL_W-1:0]    evict_count;

	// Outcomes predicted for accepted requests, oldest first.
	access_result_t pending_outcomes[$];

	function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// Makes one way the most recently used; ways that were more recent than it age by one.
	function automatic void promote_way(input int base, input int ways, input int way,
		input int old_rank);
		for (int v = 0; v < ways; v++) begin
			if (v != way && line_valid[base+v] && int'(line_rank[base+v]) < old_rank &&
				int'(line_rank[base+v]) < MAX_WAYS - 1)
				line_rank[base+v] = line_rank[base+v] + 1'b1;
		end
		line_rank[base+way] = '0;
	endfunction

	// Looks one address up in the shadow cache, updates it, and returns the outcome.
	function automatic access_result_t simulate_access(input logic [63:0] addr);
		access_result_t r;
		int s;
		int b;
		int ways;
		int base;
		int victim;
		int hit_way;
		int free_way;
		logic [63:0] tag;
		s = (int'(set_bits) > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits);
		b = int'(block_bits);
		ways = int'(ways_in_use);
		if (ways == 0)
			ways = 1;
		if (ways > MAX_WAYS)
			ways = MAX_WAYS;
		base = int'((addr >> b) & ((64'd1 << s) - 64'd1)) * MAX_WAYS;
		tag = (s + b >= 64) ? 64'd0 : (addr >> (s + b));

		// The lowest matching way hits; otherwise the lowest free way is filled.
		hit_way = -1;
		free_way = -1;
		for (int w = 0; w < ways; w++) begin
			if (hit_way < 0 && line_valid[base+w] && line_tag[base+w] == tag)
				hit_way = w;
			if (free_way < 0 && !line_valid[base+w])
				free_way = w;
		end

		if (hit_way >= 0) begin
			promote_way(base, ways, hit_way, int'(line_rank[base+hit_way]));
			hit_count = bump(hit_count);
			r.outcome = OUT_HIT;
		end else if (free_way >= 0) begin
			line_valid[base+free_way] = 1'b1;
			line_tag[base+free_way] = tag;
			promote_way(base, ways, free_way, MAX_WAYS);
			miss_count = bump(miss_count);
			r.outcome = OUT_FILL;
		end else begin
			// Oldest way is evicted; on equal ranks the lowest way goes.
			victim = 0;
			for (int w = 1; w < ways; w++) begin
				if (line_rank[base+w] > line_rank[base+victim])
					victim = w;
			end
			line_tag[base+victim] = tag;
			promote_way(base, ways, victim, int'(line_rank[base+victim]));
			miss_count = bump(miss_count);
			evict_count = bump(evict_count);
			r.outcome = OUT_EVICT;
		end
		r.hits = hit_count;
		r.misses = miss_count;
		r.evictions = evict_count;
		return r;
	endfunction

	function automatic void note_field(input string name, input logic [TOTAL_W-1:0] want,
		input logic [TOTAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches = mismatches + 1;
		end
	endfunction

	// Results are compared before the request of the same edge is predicted, since a
	// result always belongs to an earlier request.
	always @(posedge clk or negedge arst_n) begin : watch
		access_result_t predicted;
		if (!arst_n) begin
			set_bits = RST_SET_BITS;
			ways_in_use = RST_WAYS_IN_USE;
			block_bits = RST_BLOCK_BITS;
			for (int i = 0; i < LINES; i++) begin
				line_valid[i] = 1'b0;
				line_tag[i] = '0;
				line_rank[i] = '0;
			end
			hit_count = '0;
			miss_count = '0;
			evict_count = '0;
			pending_outcomes.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					$display("%0t: result with no request waiting, expected none, actual %0d",
						$time, outcome);
					mismatches = mismatches + 1;
				end else begin
					predicted = pending_outcomes.pop_front();
					note_field("outcome", TOTAL_W'(predicted.outcome), TOTAL_W'(outcome));
					note_field("hit_total", predicted.hits, hit_total);
					note_field("miss_total", predicted.misses, miss_total);
					note_field("eviction_total", predicted.evictions, eviction_total);
				end
			end

			if (in_valid && !in_stall)
				pending_outcomes.push_back(simulate_access(address));

			if (cfg_write) begin
				case (cfg_index)
					CFG_SET_BITS: set_bits = cfg_data[2:0];
					CFG_WAYS_IN_USE: ways_in_use = cfg_data[3:0];
					CFG_BLOCK_BITS: block_bits = cfg_data[5:0];
					default: ;
				endcase
			end

			outstanding <= pending_outcomes.size();
		end
	end

endmodule

// ----- sim/tb_lru_set_assoc_cache_sim.sv -----
`timescale 1ns / 100ps

// Drives address requests and configuration into the cache model; the checker beside
// it predicts and compares every result.
module tb_lru_set_assoc_cache_sim;
	import lsac_pkg::*;

	localparam int PHASES = 9;
	localparam int PHASE_REQUESTS = 50;

	// Settings of the random phases: set bits, ways and block bits, extremes included.
	localparam int PHASE_SET [PHASES]   = '{0, 6, 3, 1, 7, 5, 2, 4, 6};
	localparam int PHASE_WAYS [PHASES]  = '{8, 8, 4, 2, 15, 9, 3, 1, 5};
	localparam int PHASE_BLOCK [PHASES] = '{0, 32, 6, 33, 63, 10, 1, 4, 20};
	localparam int STEADY_PHASE = 3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [IN_ADDR_W-1:0] address = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           outcome;
	logic [TOTAL_W-1:0]   hit_total;
	logic [TOTAL_W-1:0]   miss_total;
	logic [TOTAL_W-1:0]   eviction_total;
	int                   mismatches;
	int                   outstanding;

	// When set, neither side idles.
	bit                   steady = 1'b0;

	// Effective address split of the current setting, used to shape addresses.
	int                   cur_s;
	int                   cur_b;
	int                   cur_ways;
	logic [63:0]          tag_pool [12];
	int                   pool_size;

	lru_set_assoc_cache_sim dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.outcome(outcome),
		.hit_total(hit_total),
		.miss_total(miss_total),
		.eviction_total(eviction_total)
	);

	cache_outcome_check checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.outcome(outcome),
		.hit_total(hit_total),
		.miss_total(miss_total),
		.eviction_total(eviction_total),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls at random.
	always @(posedge clk) begin
		out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 8);
	end

	// Offers one request, with a random gap first, and waits until it is taken.
	task automatic send_request(input logic [63:0] addr);
		while (!steady && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		address <= addr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stops offering requests and waits until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// Writes all three registers on consecutive edges; only called while idle.
	task automatic set_config(input int sb, input int ways, input int bb);
		cfg_write <= 1'b1;
		cfg_index <= CFG_SET_BITS;
		cfg_data <= CFG_DAT_W'(sb);
		@(posedge clk);
		cfg_index <= CFG_WAYS_IN_USE;
		cfg_data <= CFG_DAT_W'(ways);
		@(posedge clk);
		cfg_index <= CFG_BLOCK_BITS;
		cfg_data <= CFG_DAT_W'(bb);
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_s = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
		cur_b = bb;
		cur_ways = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : ways);
	endtask

	// Builds an address from tag, set and offset under the current split.
	function automatic logic [63:0] make_address(input logic [63:0] tag,
		input logic [63:0] set_idx, input logic [63:0] offset);
		logic [63:0] a;
		a = offset & ((64'd1 << cur_b) - 64'd1);
		a = a | ((set_idx & ((64'd1 << cur_s) - 64'd1)) << cur_b);
		if (cur_s + cur_b < 64)
			a = a | (tag << (cur_s + cur_b));
		return a;
	endfunction

	// Picks an address: mostly a small working set that hits and evicts, some noise.
	function automatic logic [63:0] pick_address();
		logic [63:0] set_idx;
		if ($urandom_range(0, 99) < 15)
			return {$urandom, $urandom};
		set_idx = ($urandom_range(0, 9) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
		return make_address(tag_pool[$urandom_range(0, pool_size - 1)], set_idx,
			{$urandom, $urandom});
	endfunction

	initial begin
		#5_000_000;
		$display("tb_lru_set_assoc_cache_sim failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: one way per set, so once a set holds a line every new tag in it evicts.
		send_request(64'h0);
		send_request(64'h0);
		send_request(64'hFFFF_FFFF_FFFF_FFFF);
		send_request(64'h10);
		send_request(64'h100);
		send_request(64'h0);
		send_request(64'h0F);
		drain();

		// One set of eight ways: fill all, evict the oldest, touch a middle way.
		set_config(0, 8, 0);
		for (int i = 1; i <= 8; i++)
			send_request(64'(i));
		send_request(64'd9);
		send_request(64'd3);
		send_request(64'd10);
		drain();

		// Too many set bits and ways, and the tag shifted away entirely.
		set_config(7, 15, 63);
		send_request(64'h0);
		send_request(64'h8000_0000_0000_0000);
		send_request(64'hFFFF_FFFF_FFFF_FFFF);
		send_request(64'h7FFF_FFFF_FFFF_FFFF);
		drain();

		// A way count of zero acts as one.
		set_config(2, 0, 5);
		send_request(64'h0);
		send_request(64'h80);
		send_request(64'h0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			set_config(PHASE_SET[p], PHASE_WAYS[p], PHASE_BLOCK[p]);
			steady = (p == STEADY_PHASE);
			pool_size = cur_ways + $urandom_range(0, 3);
			tag_pool[0] = '0;
			tag_pool[1] = '1;
			for (int t = 2; t < 12; t++)
				tag_pool[t] = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 15)) :
					{$urandom, $urandom};
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				// Halfway through, hold off until the cache has answered everything.
				if (n == PHASE_REQUESTS / 2)
					drain();
				send_request(pick_address());
			end
			drain();
		end
		steady = 1'b0;

		repeat (5) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_lru_set_assoc_cache_sim passed");
		else
			$display("tb_lru_set_assoc_cache_sim failed");
		$finish;
	end

endmodule
